// ===== hdl/spektrum_satellite_frame_decoder_defines.svh =====
// Assertion macros shared by the frame decoder modules.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef SPEKTRUM_SATELLITE_FRAME_DECODER_DEFINES_SVH
`define SPEKTRUM_SATELLITE_FRAME_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSFD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ssfd_pkg.sv =====
package ssfd_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP       = 1'b1;

  localparam logic [15:0] GAP_RESET     = 16'd5000;
  localparam logic [11:0] VALUE_BASE    = 12'd988;
  localparam logic [11:0] NEUTRAL_VALUE = 12'd1500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HI,
    ST_RD_LO,
    ST_WR_CH,
    ST_EMIT
  } ssfd_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // input byte transfer this cycle
    logic rd_hi;  // frame store read of a high byte
    logic rd_lo;  // frame store read of a low byte, high byte captured
    logic ch_wr;  // decode the captured word pair into the channel store
    logic emit;   // load the next receiver value into the output register
  } ssfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic decode_req;  // the offered byte lands on the last frame position
    logic more_pairs;  // another word pair remains in the frame
    logic emit_last;   // the current output channel is the final one
    logic out_free;    // the output register can take a value this cycle
  } ssfd_sts_t;

  // Output channel to channel store entry. Channels beyond the table map to themselves.
  function automatic logic [3:0] out_map(input logic [2:0] chan);
    logic [3:0] idx;
    case (chan)
      3'd0: idx = 4'd1;
      3'd1: idx = 4'd2;
      3'd2: idx = 4'd3;
      3'd3: idx = 4'd0;
      3'd4: idx = 4'd4;
      3'd5: idx = 4'd5;
      3'd6: idx = 4'd6;
      default: idx = {1'b0, chan};
    endcase
    return idx;
  endfunction

endpackage

// ===== hdl/ssfd_ctrl.sv =====
`include "spektrum_satellite_frame_decoder_defines.svh"

module ssfd_ctrl import ssfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ssfd_sts_t sts,
  output ssfd_cmd_t cmd
);

  ssfd_state_t state_r;
  ssfd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && sts.decode_req) begin
          state_nxt = ST_RD_HI;
        end
      end
      ST_RD_HI: state_nxt = ST_RD_LO;
      ST_RD_LO: state_nxt = ST_WR_CH;
      ST_WR_CH: begin
        state_nxt = sts.more_pairs ? ST_RD_HI : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
      end
      ST_RD_HI: cmd.rd_hi = 1'b1;
      ST_RD_LO: cmd.rd_lo = 1'b1;
      ST_WR_CH: cmd.ch_wr = 1'b1;
      ST_EMIT:  cmd.emit  = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  `SSFD_ASSERT_NEXT(a_last_emit_to_idle, cmd.emit && sts.emit_last, state_r == ST_IDLE, "no idle")
  `SSFD_ASSERT_NEXT(a_pair_then_read_or_emit, cmd.ch_wr, state_r == ST_RD_HI || state_r == ST_EMIT, "bad step")
  `SSFD_ASSERT_SAME(a_ready_in_idle, in_tready, state_r == ST_IDLE, "input ready while busy")

endmodule

// ===== hdl/ssfd_datapath.sv =====
`include "spektrum_satellite_frame_decoder_defines.svh"

module ssfd_datapath import ssfd_pkg::*; #(
  parameter int FRAME_BYTES    = 16,
  parameter int SERVO_CHANNELS = 7,
  parameter int RC_OUTPUTS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssfd_cmd_t            cmd,
  output ssfd_sts_t            sts,
  input  logic [7:0]           in_rx_byte,
  input  logic [31:0]          in_time_us,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2:0]           out_rc_channel,
  output logic [11:0]          out_rc_value,
  output logic                 out_last
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam int CW = (SERVO_CHANNELS > 1) ? $clog2(SERVO_CHANNELS) : 1;
  localparam logic [PW-1:0] POS_LAST     = PW'(FRAME_BYTES - 1);
  localparam logic [PW:0]   FIRST_HI     = (PW+1)'(2);
  localparam logic [PW:0]   LAST_PAIR_HI = (PW+1)'(FRAME_BYTES - 1);
  localparam logic [4:0]    SERVO_LIM    = 5'(SERVO_CHANNELS);
  localparam logic [2:0]    CHAN_LAST    = 3'(RC_OUTPUTS - 1);

  logic        mode_r;
  logic [15:0] gap_r;
  logic [31:0] last_time_r;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] pos_nxt;
  logic [PW:0]   rd_addr_r;
  logic [7:0]  hi_r;
  logic [7:0]  rdata_r;
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [10:0] chan_r [SERVO_CHANNELS];
  logic [2:0]  chan_cnt_r;
  logic        out_valid_r;
  logic [2:0]  out_chan_r;
  logic [11:0] out_value_r;
  logic        out_last_r;

  logic [31:0]   interval;
  logic          gap_hit;
  logic [PW-1:0] pos_eff;
  logic          at_last;
  logic [3:0]    word_id;
  logic [10:0]   word_val;
  logic          id_ok;
  logic [3:0]    map_idx;
  logic          map_ok;
  logic [10:0]   raw;
  logic          servo_out;
  logic [11:0]   value_nxt;

  // Frame position tracking: a long pause restarts the frame.
  always_comb begin
    interval = in_time_us - last_time_r;
    gap_hit  = interval > {16'd0, gap_r};
    pos_eff  = gap_hit ? '0 : pos_r;
    at_last  = pos_eff == POS_LAST;
    pos_nxt  = at_last ? pos_eff : pos_eff + 1'b1;
  end

  // Word pair decode from the captured high byte and the registered low byte.
  always_comb begin
    word_id  = mode_r ? hi_r[6:3] : hi_r[5:2];
    word_val = mode_r ? {hi_r[2:0], rdata_r} : {1'b0, hi_r[1:0], rdata_r};
    id_ok    = {1'b0, word_id} < SERVO_LIM;
  end

  // Receiver value for the current output channel.
  always_comb begin
    map_idx   = out_map(chan_cnt_r);
    map_ok    = {1'b0, map_idx} < SERVO_LIM;
    raw       = map_ok ? chan_r[map_idx[CW-1:0]] : '0;
    servo_out = {2'b00, chan_cnt_r} < SERVO_LIM;
    if (servo_out) begin
      value_nxt = VALUE_BASE + (mode_r ? {2'b00, raw[10:1]} : {1'b0, raw});
    end else begin
      value_nxt = NEUTRAL_VALUE;
    end
  end

  always_comb begin
    sts.decode_req = at_last;
    sts.more_pairs = rd_addr_r < LAST_PAIR_HI;
    sts.emit_last  = chan_cnt_r == CHAN_LAST;
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      gap_r  <= GAP_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_RESOLUTION_MODE: mode_r <= cfg_data[0];
        REG_FRAME_GAP:       gap_r  <= cfg_data;
        default: begin
          mode_r <= mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      pos_r       <= '0;
      rd_addr_r   <= FIRST_HI;
      chan_cnt_r  <= '0;
    end else begin
      if (cmd.take) begin
        last_time_r <= in_time_us;
        pos_r       <= pos_nxt;
        rd_addr_r   <= FIRST_HI;
        chan_cnt_r  <= '0;
      end
      if (cmd.rd_hi || cmd.rd_lo) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (cmd.emit) begin
        chan_cnt_r <= chan_cnt_r + 1'b1;
      end
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      frame_mem[pos_eff] <= in_rx_byte;
    end
    rdata_r <= frame_mem[rd_addr_r[PW-1:0]];
    if (cmd.rd_lo) begin
      hi_r <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVO_CHANNELS; i++) begin
        chan_r[i] <= '0;
      end
    end else if (cmd.ch_wr && id_ok) begin
      chan_r[word_id[CW-1:0]] <= word_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_chan_r  <= chan_cnt_r;
      out_value_r <= value_nxt;
      out_last_r  <= sts.emit_last;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_rc_channel = out_chan_r;
  assign out_rc_value   = out_value_r;
  assign out_last       = out_last_r;

  `SSFD_ASSERT_SAME(a_emit_needs_room, cmd.emit, !out_valid_r || out_tready, "output register overwritten while a value waits")
  `SSFD_ASSERT_SAME(a_low_byte_odd, cmd.rd_lo, rd_addr_r[0], "low byte read from an even frame position")
  `SSFD_ASSERT_NEXT(a_final_value_tagged, cmd.emit && sts.emit_last, out_valid_r && out_last_r, "final value of a run not marked last")

endmodule

// ===== hdl/spektrum_satellite_frame_decoder.sv =====
// Serial satellite receiver frame decoder.
//
// The slave-side stream takes one received UART byte per transfer together with
// its microsecond timestamp. A byte that arrives more than frame_gap_us after the
// previous one starts a new frame. Once a byte lands on the last frame position,
// the frame's word pairs are decoded into the channel store and RC_OUTPUTS receiver
// values leave on the master-side stream, channel 0 first, with tlast on the final one.
//
// A byte that does not complete a frame leaves the block idle, so in_tready stays high.
// A completing byte holds in_tready low while it is decoded: the frame store has
// one read port, so each of the (FRAME_BYTES - 2) / 2 word pairs costs a high-byte
// read, a low-byte read and a channel store write, and then one value per cycle is
// loaded into the output register whenever that register is free.
//
// A stalled receiver holds the output register; the decoder waits in its emit
// phase and resumes as soon as the value is taken. The output register lets the
// next input byte be accepted while the final value still waits.
// After reset the channel store is zero, the frame position and last time are zero,
// the mode is 1024 and the gap is 5000 us. The configuration channel is always ready
// and should only be written while the block is idle.
module spektrum_satellite_frame_decoder import ssfd_pkg::*; #(
  parameter int FRAME_BYTES    = 16,
  parameter int SERVO_CHANNELS = 7,
  parameter int RC_OUTPUTS     = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream, tdata fields from bit 0: rx_byte[7:0], time_us[39:8].
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,
  // Result stream, tdata fields from bit 0: rc_channel[2:0], rc_value[14:3], zero pad[15].
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,
  output logic                 out_tlast,
  // Configuration writes: index 0 is resolution_mode, index 1 is frame_gap_us.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  ssfd_cmd_t   cmd;
  ssfd_sts_t   sts;
  logic [2:0]  rc_channel;
  logic [11:0] rc_value;

  // The sender must write the registers only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  ssfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssfd_datapath #(
    .FRAME_BYTES    (FRAME_BYTES),
    .SERVO_CHANNELS (SERVO_CHANNELS),
    .RC_OUTPUTS     (RC_OUTPUTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_rx_byte     (in_tdata[7:0]),
    .in_time_us     (in_tdata[39:8]),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_rc_channel (rc_channel),
    .out_rc_value   (rc_value),
    .out_last       (out_tlast)
  );

  assign out_tdata = {1'b0, rc_value, rc_channel};

endmodule
